### rtl/qe_pkg.sv
// ----------------------------------------------------------------------------
// qe_pkg: shared definitions for the quaternion to YZX Euler unit
// Internal widths, the CORDIC angle table and the pole status codes.
// ----------------------------------------------------------------------------
package qe_pkg;

	localparam int QUAT_WIDTH_DEF  = 16;
	localparam int ANGLE_WIDTH_DEF = 16;

	// Every component is brought to Q2.14 before any arithmetic.
	localparam int COMP_W = 16;
	localparam int PROD_W = 32;
	// Operands of the arctangent units and the sums that feed them.
	localparam int OPND_W = 34;
	// Scaled norm (u) and scaled test term (m) for the attitude path.
	localparam int ROOT_W = 31;
	localparam int M_W    = 32;
	localparam int RAD_W  = 62;
	// CORDIC datapath: operands are normalized so their leading one sits at NORM_POS.
	localparam int CORD_W       = 46;
	localparam int ANG_W        = 34;
	localparam int SHIFT_W      = 6;
	localparam int NORM_POS     = 40;
	localparam int CORDIC_STEPS = 30;

	localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

	typedef enum logic [1:0] {
		ST_REGULAR = 2'd0,
		ST_NORTH   = 2'd1,
		ST_SOUTH   = 2'd2,
		ST_ZERO    = 2'd3
	} pole_status_t;

	// atan(2^-i) in Q.30, rounded.
	function automatic logic signed [ANG_W-1:0] arc_step(input int i);
		case (i)
			0:  return 34'sd843314857;
			1:  return 34'sd497837829;
			2:  return 34'sd263043837;
			3:  return 34'sd133525159;
			4:  return 34'sd67021687;
			5:  return 34'sd33543516;
			6:  return 34'sd16775851;
			7:  return 34'sd8388437;
			8:  return 34'sd4194283;
			9:  return 34'sd2097149;
			10: return 34'sd1048576;
			11: return 34'sd524288;
			12: return 34'sd262144;
			13: return 34'sd131072;
			14: return 34'sd65536;
			15: return 34'sd32768;
			16: return 34'sd16384;
			17: return 34'sd8192;
			18: return 34'sd4096;
			19: return 34'sd2048;
			20: return 34'sd1024;
			21: return 34'sd512;
			22: return 34'sd256;
			23: return 34'sd128;
			24: return 34'sd64;
			25: return 34'sd32;
			26: return 34'sd16;
			27: return 34'sd8;
			28: return 34'sd4;
			29: return 34'sd2;
			default: return '0;
		endcase
	endfunction

endpackage

### rtl/qe_quat_if.sv
// ----------------------------------------------------------------------------
// qe_quat_if: quaternion input channel
// Valid/ready channel carrying one quaternion per transaction.
// ----------------------------------------------------------------------------
interface qe_quat_if import qe_pkg::*; #(
	parameter int QUAT_WIDTH = QUAT_WIDTH_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [QUAT_WIDTH-1:0] quat_x;
	logic signed [QUAT_WIDTH-1:0] quat_y;
	logic signed [QUAT_WIDTH-1:0] quat_z;
	logic signed [QUAT_WIDTH-1:0] quat_w;

	modport source(output valid, quat_x, quat_y, quat_z, quat_w, input ready);
	modport sink(input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

### rtl/qe_euler_if.sv
// ----------------------------------------------------------------------------
// qe_euler_if: Euler angle output channel
// Valid/ready channel carrying three angles and the pole status per transaction.
// ----------------------------------------------------------------------------
interface qe_euler_if import qe_pkg::*; #(
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [ANGLE_WIDTH-1:0] angle_about_y;
	logic signed [ANGLE_WIDTH-1:0] angle_about_z;
	logic signed [ANGLE_WIDTH-1:0] angle_about_x;
	logic [1:0]                    pole_status;

	modport source(output valid, angle_about_y, angle_about_z, angle_about_x, pole_status,
		input ready);
	modport sink(input valid, angle_about_y, angle_about_z, angle_about_x, pole_status,
		output ready);
endinterface

### rtl/qe_isqrt.sv
// ----------------------------------------------------------------------------
// qe_isqrt: pipelined floor square root
// One result bit per stage, with a sideband that travels with each item.
// ----------------------------------------------------------------------------
module qe_isqrt import qe_pkg::*; #(
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [RAD_W-1:0]  rad,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root,
	output logic [SIDE_W-1:0] out_side
);

	logic [RAD_W:0]    rem_s  [1:ROOT_W];
	logic [ROOT_W-1:0] root_s [1:ROOT_W];
	logic              vld_s  [1:ROOT_W];
	logic [SIDE_W-1:0] side_s [1:ROOT_W];

	for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
		localparam int B = ROOT_W - 1 - j;
		logic [RAD_W:0]    rem_in;
		logic [ROOT_W-1:0] root_in;
		logic              vld_in;
		logic [SIDE_W-1:0] side_in;
		logic [RAD_W:0]    cand;
		logic              take;

		if (j == 0) begin : g_first
			assign rem_in  = {1'b0, rad};
			assign root_in = '0;
			assign vld_in  = in_valid;
			assign side_in = in_side;
		end else begin : g_next
			assign rem_in  = rem_s[j];
			assign root_in = root_s[j];
			assign vld_in  = vld_s[j];
			assign side_in = side_s[j];
		end

		// (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
		assign cand = ((RAD_W+1)'(root_in) << (B + 1)) + ((RAD_W+1)'(1) << (2 * B));
		assign take = (rem_in >= cand);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1]  <= take ? rem_in - cand : rem_in;
				root_s[j+1] <= take ? (root_in | (ROOT_W'(1) << B)) : root_in;
				side_s[j+1] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[ROOT_W];
	assign root      = root_s[ROOT_W];
	assign out_side  = side_s[ROOT_W];

endmodule

### rtl/qe_cordic.sv
// ----------------------------------------------------------------------------
// qe_cordic: pipelined vectoring CORDIC, several lanes in lock step
// Normalizes each operand pair, folds it into the right half plane and runs
// one micro-rotation per stage, giving atan2 in Q.30.
// ----------------------------------------------------------------------------
module qe_cordic import qe_pkg::*; #(
	parameter int LANES  = 3,
	parameter int SIDE_W = 2
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_valid,
	input  logic signed [OPND_W-1:0] in_y [LANES],
	input  logic signed [OPND_W-1:0] in_x [LANES],
	input  logic [SIDE_W-1:0]       in_side,
	output logic                    out_valid,
	output logic signed [ANG_W-1:0] ang [LANES],
	output logic [SIDE_W-1:0]       out_side
);

	function automatic logic [SHIFT_W-1:0] lead_pos(input logic [OPND_W-1:0] m);
		logic [SHIFT_W-1:0] p;
		p = '0;
		for (int i = 0; i < OPND_W; i++) begin
			if (m[i]) begin
				p = SHIFT_W'(i);
			end
		end
		return p;
	endfunction

	// Stage 1: normalizing shift amount.
	logic signed [OPND_W-1:0]  x_s1    [LANES];
	logic signed [OPND_W-1:0]  y_s1    [LANES];
	logic [SHIFT_W-1:0]        k_s1    [LANES];
	logic                      zero_s1 [LANES];
	logic                      vld_s1;
	logic [SIDE_W-1:0]         side_s1;

	// Index 0 is the shifted and folded vector, index s+1 follows micro-rotation s.
	logic signed [CORD_W-1:0]  xi_s  [LANES][CORDIC_STEPS+1];
	logic signed [CORD_W-1:0]  yi_s  [LANES][CORDIC_STEPS+1];
	logic signed [ANG_W-1:0]   ai_s  [LANES][CORDIC_STEPS+1];
	logic                      zr_s  [LANES][CORDIC_STEPS+1];
	logic                      vld_s [CORDIC_STEPS+1];
	logic [SIDE_W-1:0]         side_s[CORDIC_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s1   <= in_valid;
			vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1   <= in_side;
			side_s[0] <= side_s1;
		end
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [OPND_W-1:0]        mag_x;
		logic [OPND_W-1:0]        mag_y;
		logic signed [CORD_W-1:0] xs;
		logic signed [CORD_W-1:0] ys;
		logic signed [CORD_W-1:0] nx;
		logic signed [CORD_W-1:0] ny;
		logic signed [ANG_W-1:0]  na;

		assign mag_x = in_x[l][OPND_W-1] ? $unsigned(-in_x[l]) : $unsigned(in_x[l]);
		assign mag_y = in_y[l][OPND_W-1] ? $unsigned(-in_y[l]) : $unsigned(in_y[l]);

		always_ff @(posedge clk) begin
			if (en) begin
				x_s1[l]    <= in_x[l];
				y_s1[l]    <= in_y[l];
				k_s1[l]    <= SHIFT_W'(NORM_POS) - lead_pos(mag_x | mag_y);
				zero_s1[l] <= (in_x[l] == '0) && (in_y[l] == '0);
			end
		end

		assign xs = CORD_W'(x_s1[l]) <<< k_s1[l];
		assign ys = CORD_W'(y_s1[l]) <<< k_s1[l];

		// A vector in the left half plane is turned by a quarter turn first.
		always_comb begin
			nx = xs;
			ny = ys;
			na = '0;
			if (xs < 0) begin
				if (ys >= 0) begin
					nx = ys;
					ny = -xs;
					na = HALF_PI_Q30;
				end else begin
					nx = -ys;
					ny = xs;
					na = -HALF_PI_Q30;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				xi_s[l][0] <= nx;
				yi_s[l][0] <= ny;
				ai_s[l][0] <= na;
				zr_s[l][0] <= zero_s1[l];
			end
		end

		// Both operands zero gives a zero angle.
		assign ang[l] = zr_s[l][CORDIC_STEPS] ? '0 : ai_s[l][CORDIC_STEPS];
	end

	for (genvar s = 0; s < CORDIC_STEPS; s++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s+1] <= 1'b0;
			end else if (en) begin
				vld_s[s+1] <= vld_s[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[s+1] <= side_s[s];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_rot
			logic signed [CORD_W-1:0] dx;
			logic signed [CORD_W-1:0] dy;
			logic                     cw;

			assign dx = yi_s[l][s] >>> s;
			assign dy = xi_s[l][s] >>> s;
			assign cw = (yi_s[l][s] > 0);

			always_ff @(posedge clk) begin
				if (en) begin
					xi_s[l][s+1] <= cw ? xi_s[l][s] + dx : xi_s[l][s] - dx;
					yi_s[l][s+1] <= cw ? yi_s[l][s] - dy : yi_s[l][s] + dy;
					ai_s[l][s+1] <= cw ? ai_s[l][s] + arc_step(s) : ai_s[l][s] - arc_step(s);
					zr_s[l][s+1] <= zr_s[l][s];
				end
			end
		end
	end

	assign out_valid = vld_s[CORDIC_STEPS];
	assign out_side  = side_s[CORDIC_STEPS];

endmodule

### rtl/quaternion_to_yzx_euler_unit.sv
// ----------------------------------------------------------------------------
// quaternion_to_yzx_euler_unit: quaternion to YZX Euler angles
// Converts one Q2.14 quaternion into heading, attitude and bank in Q3.12
// radians, with north pole, south pole and zero-norm detection.
// ----------------------------------------------------------------------------
// Usage
//   The quat channel takes one quaternion per transaction; the euler channel
//   returns one result transaction per quaternion, in the same order.
//   From the accepting edge to euler.valid a quaternion passes seven
//   arithmetic stages (input register, products, sums, pole test and
//   scaling, clamp, squares, difference), 31 square root stages (one root
//   bit each), 32 CORDIC stages (two for normalization, thirty
//   micro-rotations) and the output register, where the accepting edge
//   itself loads the first stage.
//   Throughput is one quaternion per cycle while the skid register is empty; the
//   pipeline depth is set by the bit-serial square root and the CORDIC micro-rotations.
//   Reset clears every valid bit, so the block comes out of reset empty with
//   quat.ready high and euler.valid low.
//   When the receiver stalls, a result waits in the output register and the
//   pipeline keeps moving until one more result is parked in a skid register;
//   only then does quat.ready drop and the whole pipeline hold. Nothing is
//   dropped or duplicated by a stall.
// ----------------------------------------------------------------------------
module quaternion_to_yzx_euler_unit import qe_pkg::*; #(
	parameter int QUAT_WIDTH  = QUAT_WIDTH_DEF,
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
	input logic       clk,
	input logic       arst_n,
	qe_quat_if.sink   quat,
	qe_euler_if.source euler
);

	localparam int LANE_Y = 0;
	localparam int LANE_X = 1;
	localparam int LANE_Z = 2;
	localparam int LANES  = 3;

	// Output conversion from Q.30 to Q3.(ANGLE_WIDTH-4) with round half up.
	localparam int FMT_W = ANG_W + 3;
	localparam int SH    = ANG_W - ANGLE_WIDTH;
	localparam logic signed [FMT_W-1:0] HALF_LSB = FMT_W'(1) <<< (SH - 1);
	localparam logic signed [FMT_W-1:0] MAX_V = (FMT_W'(1) <<< (ANGLE_WIDTH - 1)) - FMT_W'(1);
	localparam logic signed [FMT_W-1:0] MIN_V = -MAX_V - FMT_W'(1);

	// What rides alongside the square root: everything the CORDIC lanes need besides the root.
	typedef struct packed {
		pole_status_t             st;
		logic signed [M_W-1:0]    m;
		logic signed [OPND_W-1:0] yy;
		logic signed [OPND_W-1:0] yx;
		logic signed [OPND_W-1:0] xy;
		logic signed [OPND_W-1:0] xx;
	} side_t;

	typedef struct packed {
		logic signed [ANGLE_WIDTH-1:0] ay;
		logic signed [ANGLE_WIDTH-1:0] az;
		logic signed [ANGLE_WIDTH-1:0] ax;
		pole_status_t                  st;
	} result_t;

	function automatic logic signed [ANGLE_WIDTH-1:0] to_field(
		input logic signed [FMT_W-1:0] a
	);
		logic signed [FMT_W-1:0] r;
		r = (a + HALF_LSB) >>> SH;
		if (r > MAX_V) begin
			r = MAX_V;
		end else if (r < MIN_V) begin
			r = MIN_V;
		end
		return r[ANGLE_WIDTH-1:0];
	endfunction

	// The whole pipeline moves together; it holds only while the skid is full.
	logic adv;
	logic skid_v_q;
	logic out_v_q;
	result_t out_q;
	result_t skid_q;

	assign adv        = !skid_v_q;
	assign quat.ready = adv;

	// Bring every component to Q2.14: wider inputs drop low bits (floor),
	// narrower inputs are padded with zeros on the right.
	logic signed [COMP_W-1:0] qn_x, qn_y, qn_z, qn_w;

	if (QUAT_WIDTH > COMP_W) begin : g_narrow
		assign qn_x = quat.quat_x[QUAT_WIDTH-1 -: COMP_W];
		assign qn_y = quat.quat_y[QUAT_WIDTH-1 -: COMP_W];
		assign qn_z = quat.quat_z[QUAT_WIDTH-1 -: COMP_W];
		assign qn_w = quat.quat_w[QUAT_WIDTH-1 -: COMP_W];
	end else if (QUAT_WIDTH < COMP_W) begin : g_widen
		assign qn_x = {quat.quat_x, {(COMP_W - QUAT_WIDTH){1'b0}}};
		assign qn_y = {quat.quat_y, {(COMP_W - QUAT_WIDTH){1'b0}}};
		assign qn_z = {quat.quat_z, {(COMP_W - QUAT_WIDTH){1'b0}}};
		assign qn_w = {quat.quat_w, {(COMP_W - QUAT_WIDTH){1'b0}}};
	end else begin : g_same
		assign qn_x = quat.quat_x;
		assign qn_y = quat.quat_y;
		assign qn_z = quat.quat_z;
		assign qn_w = quat.quat_w;
	end

	// Stage 1: input register.
	logic                     v_s1;
	logic signed [COMP_W-1:0] qx_s1, qy_s1, qz_s1, qw_s1;

	// Stage 2: the ten products.
	logic                     v_s2;
	logic signed [PROD_W-1:0] sx_s2, sy_s2, sz_s2, sw_s2;
	logic signed [PROD_W-1:0] pxy_s2, pzw_s2, pyw_s2, pxz_s2, pxw_s2, pyz_s2;
	logic signed [COMP_W-1:0] qx_s2, qw_s2;

	// Stage 3: norm, test term and the regular-case arctangent operands.
	logic                     v_s3;
	logic signed [OPND_W-1:0] norm_s3;
	logic signed [OPND_W-2:0] test_s3;
	logic signed [OPND_W-1:0] ayy_s3, ayx_s3, axy_s3, axx_s3;
	logic signed [COMP_W-1:0] qx_s3, qw_s3;

	// Stage 4: pole decision, heading operand choice and norm scaling.
	logic                     v_s4;
	pole_status_t             st_s4;
	logic [ROOT_W-1:0]        u_s4;
	logic signed [OPND_W-1:0] m_s4;
	logic signed [OPND_W-1:0] yy_s4, yx_s4, xy_s4, xx_s4;

	// Stages 5 to 7: clamp, squares, radicand.
	logic              v_s5, v_s6, v_s7;
	logic [ROOT_W-1:0] u_s5;
	logic [ROOT_W-1:0] mabs_s5;
	logic [RAD_W-1:0]  uu_s6, mm_s6;
	logic [RAD_W-1:0]  rad_s7;
	side_t             side_s5, side_s6, side_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= quat.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			qx_s1 <= qn_x;
			qy_s1 <= qn_y;
			qz_s1 <= qn_z;
			qw_s1 <= qn_w;

			sx_s2  <= qx_s1 * qx_s1;
			sy_s2  <= qy_s1 * qy_s1;
			sz_s2  <= qz_s1 * qz_s1;
			sw_s2  <= qw_s1 * qw_s1;
			pxy_s2 <= qx_s1 * qy_s1;
			pzw_s2 <= qz_s1 * qw_s1;
			pyw_s2 <= qy_s1 * qw_s1;
			pxz_s2 <= qx_s1 * qz_s1;
			pxw_s2 <= qx_s1 * qw_s1;
			pyz_s2 <= qy_s1 * qz_s1;
			qx_s2  <= qx_s1;
			qw_s2  <= qw_s1;

			norm_s3 <= OPND_W'(sx_s2) + OPND_W'(sy_s2) + OPND_W'(sz_s2) + OPND_W'(sw_s2);
			test_s3 <= (OPND_W-1)'(pxy_s2) + (OPND_W-1)'(pzw_s2);
			ayy_s3  <= (OPND_W'(pyw_s2) - OPND_W'(pxz_s2)) <<< 1;
			ayx_s3  <= OPND_W'(sx_s2) - OPND_W'(sy_s2) - OPND_W'(sz_s2) + OPND_W'(sw_s2);
			axy_s3  <= (OPND_W'(pxw_s2) - OPND_W'(pyz_s2)) <<< 1;
			axx_s3  <= OPND_W'(sy_s2) - OPND_W'(sx_s2) - OPND_W'(sz_s2) + OPND_W'(sw_s2);
			qx_s3   <= qx_s2;
			qw_s3   <= qw_s2;
		end
	end

	// Pole test: 1000 * test against +-499 * norm, exact in integers.
	logic signed [OPND_W+9:0] t1000, n499;
	logic signed [OPND_W-1:0] m2;
	pole_status_t             st_next;

	assign t1000 = (OPND_W+10)'(test_s3) * (OPND_W+10)'(1000);
	assign n499  = (OPND_W+10)'(norm_s3) * (OPND_W+10)'(499);
	assign m2    = $signed({test_s3, 1'b0});

	always_comb begin
		if (norm_s3 == '0) begin
			st_next = ST_ZERO;
		end else if (t1000 > n499) begin
			st_next = ST_NORTH;
		end else if (t1000 < -n499) begin
			st_next = ST_SOUTH;
		end else begin
			st_next = ST_REGULAR;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s4 <= st_next;
			// The norm never exceeds 2^32, so at most two halvings bring it below 2^31.
			if (norm_s3[32]) begin
				u_s4 <= norm_s3[32:2];
				m_s4 <= m2 >>> 2;
			end else if (norm_s3[31]) begin
				u_s4 <= norm_s3[31:1];
				m_s4 <= m2 >>> 1;
			end else begin
				u_s4 <= norm_s3[30:0];
				m_s4 <= m2;
			end
			// At a pole the heading is the angle of (x, w), doubled later.
			if (st_next == ST_NORTH || st_next == ST_SOUTH) begin
				yy_s4 <= OPND_W'(qx_s3);
				yx_s4 <= OPND_W'(qw_s3);
			end else begin
				yy_s4 <= ayy_s3;
				yx_s4 <= ayx_s3;
			end
			xy_s4 <= axy_s3;
			xx_s4 <= axx_s3;
		end
	end

	// The ratio 2t/n is clamped to [-1, 1] by clamping m to [-u, u].
	logic signed [OPND_W-1:0] u_ext, m_clamp, m_neg;

	always_comb begin
		u_ext = $signed({{(OPND_W - ROOT_W){1'b0}}, u_s4});
		if (m_s4 > u_ext) begin
			m_clamp = u_ext;
		end else if (m_s4 < -u_ext) begin
			m_clamp = -u_ext;
		end else begin
			m_clamp = m_s4;
		end
		m_neg = -m_clamp;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s5       <= u_s4;
			mabs_s5    <= m_clamp[OPND_W-1] ? m_neg[ROOT_W-1:0] : m_clamp[ROOT_W-1:0];
			side_s5.st <= st_s4;
			side_s5.m  <= m_clamp[M_W-1:0];
			side_s5.yy <= yy_s4;
			side_s5.yx <= yx_s4;
			side_s5.xy <= xy_s4;
			side_s5.xx <= xx_s4;

			uu_s6   <= RAD_W'(u_s5) * RAD_W'(u_s5);
			mm_s6   <= RAD_W'(mabs_s5) * RAD_W'(mabs_s5);
			side_s6 <= side_s5;

			rad_s7  <= uu_s6 - mm_s6;
			side_s7 <= side_s6;
		end
	end

	// Square root of u^2 - m^2, the cosine leg of the attitude angle.
	logic              sq_valid;
	logic [ROOT_W-1:0] sq_root;
	logic [$bits(side_t)-1:0] sq_side_bits;
	side_t             sq_side;

	qe_isqrt #(
		.SIDE_W($bits(side_t))
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s7),
		.rad      (rad_s7),
		.in_side  (side_s7),
		.out_valid(sq_valid),
		.root     (sq_root),
		.out_side (sq_side_bits)
	);

	assign sq_side = side_t'(sq_side_bits);

	// Three arctangent lanes: heading, bank and attitude.
	logic signed [OPND_W-1:0] cy [LANES];
	logic signed [OPND_W-1:0] cx [LANES];
	logic signed [ANG_W-1:0]  cang [LANES];
	logic                     c_valid;
	logic [1:0]               c_side;
	pole_status_t             c_st;

	assign cy[LANE_Y] = sq_side.yy;
	assign cx[LANE_Y] = sq_side.yx;
	assign cy[LANE_X] = sq_side.xy;
	assign cx[LANE_X] = sq_side.xx;
	assign cy[LANE_Z] = OPND_W'(sq_side.m);
	assign cx[LANE_Z] = $signed({{(OPND_W - ROOT_W){1'b0}}, sq_root});

	qe_cordic #(
		.LANES (LANES),
		.SIDE_W(2)
	) u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (sq_valid),
		.in_y     (cy),
		.in_x     (cx),
		.in_side  (sq_side.st),
		.out_valid(c_valid),
		.ang      (cang),
		.out_side (c_side)
	);

	assign c_st = pole_status_t'(c_side);

	// Final angle selection by pole status, then rounding and saturation.
	logic signed [FMT_W-1:0] fy, fz, fx, head2;
	result_t                 res;

	always_comb begin
		head2 = FMT_W'(cang[LANE_Y]) <<< 1;
		fy = '0;
		fz = '0;
		fx = '0;
		case (c_st)
			ST_REGULAR: begin
				fy = FMT_W'(cang[LANE_Y]);
				fz = FMT_W'(cang[LANE_Z]);
				fx = FMT_W'(cang[LANE_X]);
			end
			ST_NORTH: begin
				fy = head2;
				fz = FMT_W'(HALF_PI_Q30);
			end
			ST_SOUTH: begin
				fy = -head2;
				fz = -FMT_W'(HALF_PI_Q30);
			end
			default: begin
				fy = '0;
			end
		endcase
		res.ay = to_field(fy);
		res.az = to_field(fz);
		res.ax = to_field(fx);
		res.st = c_st;
	end

	// Output register with a one-entry skid behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || euler.ready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= c_valid;
			end
		end else if (c_valid && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || euler.ready) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (c_valid && !skid_v_q) begin
			skid_q <= res;
		end
	end

	assign euler.valid         = out_v_q;
	assign euler.angle_about_y = out_q.ay;
	assign euler.angle_about_z = out_q.az;
	assign euler.angle_about_x = out_q.ax;
	assign euler.pole_status   = out_q.st;

	// A parked result always has a result in front of it.
	a_skid_behind_output: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register holds a result while the output register is empty");

	// A zero quaternion reports three zero angles.
	a_zero_angles: assert property (@(posedge clk) disable iff (!arst_n)
		(euler.valid && euler.pole_status == ST_ZERO) |->
		(euler.angle_about_y == '0 && euler.angle_about_z == '0 &&
		euler.angle_about_x == '0))
		else $error("zero-norm result carries a nonzero angle");

	// At either pole the bank angle is zero.
	a_pole_bank: assert property (@(posedge clk) disable iff (!arst_n)
		(euler.valid && (euler.pole_status == ST_NORTH || euler.pole_status == ST_SOUTH)) |->
		(euler.angle_about_x == '0))
		else $error("pole result carries a nonzero bank angle");

	// A full skid stops intake until it drains.
	a_hold_intake: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> !quat.ready)
		else $error("quaternion accepted while the skid register is full");

endmodule
